// ===== hw/rtl/spq_pkg.sv =====
package spq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned OP_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_PEEK   = 2'd2
  } op_t;

  typedef struct packed {
    logic               ins;
    logic               rem;
    logic [VAL_W-1:0]   value;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/sorted_priority_queue.sv =====
// Minimum priority queue of spq_pkg::DEPTH signed 32-bit entries, kept in
// ascending order in a row of cells. A request is taken at a rising edge
// where start is high and busy is low; busy never rises, so a request can
// be taken in every cycle. in_op selects insert, remove of the smallest entry,
// or peek at the smallest entry, and in_item_value carries the insert value.
// Every request gives one result in the cycle after it is taken: out_valid is
// high for that single cycle with out_head_value, out_was_empty and
// out_dropped_full. The throughput is one request per cycle, set by the
// single compare in each cell, which all cells do in parallel against the
// broadcast value. Equal values keep arrival order. A remove or peek on an
// empty queue returns zero with out_was_empty set; an insert into a full
// queue is discarded with out_dropped_full set. Reset empties the queue and
// clears out_valid. The receiver cannot stall, so a result must be captured
// in the cycle that out_valid is high.
module sorted_priority_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [spq_pkg::OP_W-1:0]    in_op,
  input  logic [spq_pkg::VAL_W-1:0]   in_item_value,
  output logic                        out_valid,
  output logic [spq_pkg::VAL_W-1:0]   out_head_value,
  output logic                        out_was_empty,
  output logic                        out_dropped_full
);

  localparam int unsigned D = spq_pkg::DEPTH;

  spq_pkg::cell_ctrl_t       ctrl;
  logic [D-1:0]              place;
  logic [D-1:0]              valid;
  logic [spq_pkg::VAL_W-1:0] value [D];

  logic                      out_valid_r;
  logic [spq_pkg::VAL_W-1:0] head_r;
  logic [spq_pkg::VAL_W-1:0] head_nxt;
  logic                      empty_r;
  logic                      empty_nxt;
  logic                      full_r;
  logic                      full_nxt;
  logic                      accept;
  logic                      queue_empty;
  logic                      is_full;

  assign busy        = 1'b0;
  assign accept      = start && !busy;
  assign queue_empty = !valid[0];
  assign is_full     = valid[D-1];

  always_comb begin
    ctrl.ins   = 1'b0;
    ctrl.rem   = 1'b0;
    ctrl.value = in_item_value;
    head_nxt   = '0;
    empty_nxt  = 1'b0;
    full_nxt   = 1'b0;
    unique case (in_op)
      spq_pkg::OP_INSERT: begin
        full_nxt = is_full;
        ctrl.ins = accept && !is_full;
      end
      spq_pkg::OP_REMOVE: begin
        empty_nxt = queue_empty;
        head_nxt  = queue_empty ? '0 : value[0];
        ctrl.rem  = accept && !queue_empty;
      end
      spq_pkg::OP_PEEK: begin
        empty_nxt = queue_empty;
        head_nxt  = queue_empty ? '0 : value[0];
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < D; i++) begin : g_cell
    logic                      lp;
    logic                      lv;
    logic [spq_pkg::VAL_W-1:0] lval;
    logic                      rv;
    logic [spq_pkg::VAL_W-1:0] rval;

    if (i == 0) begin : g_first
      assign lp   = 1'b0;
      assign lv   = 1'b1;
      assign lval = '0;
    end else begin : g_mid
      assign lp   = place[i-1];
      assign lv   = valid[i-1];
      assign lval = value[i-1];
    end

    if (i == D - 1) begin : g_last
      assign rv   = 1'b0;
      assign rval = '0;
    end else begin : g_inner
      assign rv   = valid[i+1];
      assign rval = value[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .left_place  (lp),
      .left_valid  (lv),
      .left_value  (lval),
      .right_valid (rv),
      .right_value (rval),
      .place       (place[i]),
      .valid       (valid[i]),
      .value       (value[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      head_r  <= head_nxt;
      empty_r <= empty_nxt;
      full_r  <= full_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_head_value   = head_r;
  assign out_was_empty    = empty_r;
  assign out_dropped_full = full_r;

endmodule

// ===== hw/rtl/spq_cell.sv =====
module spq_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  spq_pkg::cell_ctrl_t         ctrl,
  input  logic                        left_place,
  input  logic                        left_valid,
  input  logic [spq_pkg::VAL_W-1:0]   left_value,
  input  logic                        right_valid,
  input  logic [spq_pkg::VAL_W-1:0]   right_value,
  output logic                        place,
  output logic                        valid,
  output logic [spq_pkg::VAL_W-1:0]   value
);

  logic                      valid_r;
  logic                      valid_nxt;
  logic [spq_pkg::VAL_W-1:0] value_r;
  logic [spq_pkg::VAL_W-1:0] value_nxt;

  // An empty cell behaves as if it held a value larger than any request.
  assign place = !valid_r || ($signed(value_r) > $signed(ctrl.value));

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    if (ctrl.ins) begin
      valid_nxt = valid_r || left_valid;
      if (place) begin
        value_nxt = left_place ? left_value : ctrl.value;
      end
    end else if (ctrl.rem) begin
      valid_nxt = right_valid;
      value_nxt = right_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign valid = valid_r;
  assign value = value_r;

endmodule

// ===== tb/sv/sorted_priority_queue_tb.sv =====
`timescale 1ns / 1ps

module sorted_priority_queue_tb;
  import spq_pkg::*;

  localparam logic [OP_W-1:0] OP_IDLE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_REQUESTS = 400;
  localparam int unsigned DRAIN_CYCLES = 4;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [VAL_W-1:0] value;
    logic             drain_first;
  } queue_request_t;

  typedef struct packed {
    logic [VAL_W-1:0] head_value;
    logic             was_empty;
    logic             dropped_full;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [OP_W-1:0] in_op = '0;
  logic [VAL_W-1:0] in_item_value = '0;
  logic busy;
  logic out_valid;
  logic [VAL_W-1:0] out_head_value;
  logic out_was_empty;
  logic out_dropped_full;

  queue_request_t pending_requests[$];
  queue_result_t expected_results[$];
  logic [VAL_W-1:0] model_cells [DEPTH];
  int unsigned model_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  logic req_taken = 1'b0;

  sorted_priority_queue u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_item_value    (in_item_value),
    .out_valid        (out_valid),
    .out_head_value   (out_head_value),
    .out_was_empty    (out_was_empty),
    .out_dropped_full (out_dropped_full)
  );

  always #5 clk = ~clk;

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%s", msg);
    end
  endtask

  task automatic add_request(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] value,
                             input logic drain_first);
    queue_request_t req;
    req.op = op;
    req.value = value;
    req.drain_first = drain_first;
    pending_requests.push_back(req);
  endtask

  task automatic predict_queue_op(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] value,
                                  output queue_result_t res);
    int pos;
    res = '0;
    if (op == OP_INSERT) begin
      if (model_count >= DEPTH) begin
        res.dropped_full = 1'b1;
      end else begin
        pos = model_count;
        while (pos > 0 && $signed(model_cells[pos-1]) > $signed(value)) begin
          model_cells[pos] = model_cells[pos-1];
          pos--;
        end
        model_cells[pos] = value;
        model_count++;
      end
    end else if (op == OP_REMOVE || op == OP_PEEK) begin
      if (model_count == 0) begin
        res.was_empty = 1'b1;
      end else begin
        res.head_value = model_cells[0];
        if (op == OP_REMOVE) begin
          for (int i = 1; i < model_count; i++) begin
            model_cells[i-1] = model_cells[i];
          end
          model_count--;
        end
      end
    end
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    logic [VAL_W-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'h0000_0000;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      1, 2, 3: v = $urandom_range(0, 20) - 10;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  always @(negedge clk) begin
    queue_request_t req;
    logic next_start;
    logic [OP_W-1:0] next_op;
    logic [VAL_W-1:0] next_value;
    next_start = start;
    next_op = in_op;
    next_value = in_item_value;
    if (rst_n && !(start && !req_taken)) begin
      next_start = 1'b0;
      next_op = OP_W'($urandom_range(0, 3));
      next_value = $urandom;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_requests.size() > 0 &&
                   !(pending_requests[0].drain_first && expected_results.size() > 0)) begin
        req = pending_requests.pop_front();
        next_start = 1'b1;
        next_op = req.op;
        next_value = req.value;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
    start <= next_start;
    in_op <= next_op;
    in_item_value <= next_value;
  end

  always @(posedge clk) begin
    queue_result_t got;
    queue_result_t want;
    queue_result_t predicted;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sorted_priority_queue: mismatch");
      $finish;
    end else begin
      req_taken <= rst_n && start && !busy;
      if (rst_n) begin
        if (out_valid) begin
          got.head_value = out_head_value;
          got.was_empty = out_was_empty;
          got.dropped_full = out_dropped_full;
          if (expected_results.size() == 0) begin
            note_mismatch($sformatf("unexpected result head %0d empty %0b full %0b",
                                    $signed(got.head_value), got.was_empty, got.dropped_full));
          end else begin
            want = expected_results.pop_front();
            if (got.head_value !== want.head_value || got.was_empty !== want.was_empty ||
                got.dropped_full !== want.dropped_full) begin
              note_mismatch($sformatf(
                "head exp %0d got %0d, empty exp %0b got %0b, full exp %0b got %0b",
                $signed(want.head_value), $signed(got.head_value), want.was_empty, got.was_empty,
                want.dropped_full, got.dropped_full));
            end
          end
        end
        if (start && !busy) begin
          predict_queue_op(in_op, in_item_value, predicted);
          expected_results.push_back(predicted);
        end
      end
    end
  end

  initial begin
    logic [VAL_W-1:0] fill_values [16];
    int unsigned phase_len;
    int unsigned phase_kind;
    int unsigned roll;
    int unsigned made;
    logic [OP_W-1:0] op;
    fill_values = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                    32'd5, 32'd5, 32'd1, 32'hFFFF_FFFB, 32'd100, 32'h7FFF_FFFE,
                    32'h8000_0001, 32'd7, 32'd5, 32'hFFFF_FFFF, 32'd3, 32'd2};

    add_request(OP_PEEK, 32'h1234_5678, 1'b0);
    add_request(OP_REMOVE, 32'hFFFF_FFFF, 1'b0);
    add_request(OP_IDLE, 32'hA5A5_A5A5, 1'b0);
    foreach (fill_values[i]) begin
      add_request(OP_INSERT, fill_values[i], 1'b0);
    end
    add_request(OP_INSERT, 32'd42, 1'b0);
    add_request(OP_PEEK, 32'h0, 1'b0);
    add_request(OP_REMOVE, 32'h0, 1'b0);
    add_request(OP_REMOVE, 32'h0, 1'b0);
    add_request(OP_IDLE, 32'h5A5A_5A5A, 1'b1);

    made = 0;
    while (made < RANDOM_REQUESTS) begin
      phase_kind = $urandom_range(0, 2);
      phase_len = $urandom_range(10, 40);
      for (int k = 0; k < phase_len; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
          op = OP_IDLE;
        end else if (phase_kind == 0) begin
          op = (roll < 80) ? OP_INSERT : ((roll < 92) ? OP_REMOVE : OP_PEEK);
        end else if (phase_kind == 1) begin
          op = (roll < 25) ? OP_INSERT : ((roll < 85) ? OP_REMOVE : OP_PEEK);
        end else begin
          op = (roll < 45) ? OP_INSERT : ((roll < 80) ? OP_REMOVE : OP_PEEK);
        end
        add_request(op, pick_value(), $urandom_range(0, 49) == 0);
        made++;
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() > 0 || start || expected_results.size() > 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (expected_results.size() > 0) begin
      note_mismatch($sformatf("%0d expected results never arrived", expected_results.size()));
    end
    if (mismatch_count == 0) begin
      $display("sorted_priority_queue: match");
    end else begin
      $display("sorted_priority_queue: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue.sv
tb/sv/sorted_priority_queue_tb.sv
